### rtl/core/ulf_pkg.sv
// ----------------------------------------------------------------------------
// ulf_pkg
// Shared types, constants and character functions for the UTF-8 fold and
// leet normalizer.
// ----------------------------------------------------------------------------
package ulf_pkg;

    // Counter and limit widths
    localparam int COUNT_BITS = 12;
    localparam int LIMIT_W    = 12;
    localparam int CMP_W      = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
    localparam int CFG_IDX_W  = 1;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [LIMIT_W-1:0]    t_limit;
    typedef logic [CMP_W-1:0]      t_cmp;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;

    localparam t_count COUNT_MAX = '1;
    localparam t_count COUNT_TWO = t_count'(2);

    // Configuration register indexes
    localparam t_cfg_idx REG_PRE_LIMIT = t_cfg_idx'(0);
    localparam t_cfg_idx REG_OUT_LIMIT = t_cfg_idx'(1);

    localparam t_limit PRE_LIMIT_RST = t_limit'(4090);
    localparam t_limit OUT_LIMIT_RST = t_limit'(4095);

    // Byte codes
    localparam logic [7:0] LEAD_C3   = 8'hC3;
    localparam logic [7:0] MASK_2B   = 8'hE0;
    localparam logic [7:0] CODE_2B   = 8'hC0;
    localparam logic [7:0] MASK_3B   = 8'hF0;
    localparam logic [7:0] CODE_3B   = 8'hE0;
    localparam logic [7:0] MASK_4B   = 8'hF8;
    localparam logic [7:0] CODE_4B   = 8'hF0;
    localparam logic [7:0] CONT_LO   = 8'h80;
    localparam logic [7:0] CONT_HI   = 8'hBF;
    localparam logic [7:0] CH_QUEST  = "?";
    localparam logic [7:0] CH_UP_A   = "A";
    localparam logic [7:0] CH_UP_Z   = "Z";
    localparam logic [7:0] CH_TIMES  = "x";
    localparam logic [7:0] CH_DIVIDE = "/";

    // Latin-1 fold table for the second byte of a 0xC3 sequence, entry 0 first
    localparam int FOLD_N = 64;
    localparam logic [FOLD_N*8-1:0] FOLD_TABLE =
        {"AAAAAAECEEEEIIIIDNOOOOOxOUUUUYPs", "aaaaaaeceeeeiiiidnooooo/ouuuuypy"};

    // Per-text state
    typedef struct packed {
        logic [1:0] skip_left;
        logic       c3_pend;
        logic [7:0] last_out;
        logic [7:0] second_out;
        t_count     produced;
        t_count     emitted;
        logic       stopped;
        logic       cut;
    } t_state;

    // One result beat
    typedef struct packed {
        logic [7:0] out_char;
        logic       has_char;
        logic       end_of_text;
        logic       truncated;
    } t_result;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= CH_UP_A && c <= CH_UP_Z) ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] fold_second(input logic [7:0] c1);
        logic [7:0] b;
        b = FOLD_TABLE[(FOLD_N - 1 - int'(c1[5:0])) * 8 +: 8];
        if (c1 < CONT_LO || c1 > CONT_HI) return CH_QUEST;
        if (b == CH_TIMES || b == CH_DIVIDE) return CH_QUEST;
        return to_lower(b);
    endfunction

    function automatic logic [7:0] leet(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            "1", "!", "|": r = "i";
            "0":           r = "o";
            "@":           r = "a";
            "$":           r = "s";
            "3":           r = "e";
            default:       r = c;
        endcase
        return r;
    endfunction

    // Continuation bytes to skip after a bad lead
    function automatic logic [1:0] seq_skip(input logic [7:0] b);
        if ((b & MASK_2B) == CODE_2B) return 2'd1;
        if ((b & MASK_3B) == CODE_3B) return 2'd2;
        if ((b & MASK_4B) == CODE_4B) return 2'd3;
        return 2'd0;
    endfunction

endpackage

### rtl/core/ulf_in_if.sv
// ----------------------------------------------------------------------------
// ulf_in_if
// Input byte channel: valid/ready with one text byte per beat.
// ----------------------------------------------------------------------------
interface ulf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_last;

    modport source (output valid, output in_byte, output is_last, input ready);
    modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

### rtl/core/ulf_out_if.sv
// ----------------------------------------------------------------------------
// ulf_out_if
// Result channel: valid/ready with at most one normalized character per beat.
// ----------------------------------------------------------------------------
interface ulf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       has_char;
    logic       end_of_text;
    logic       truncated;

    modport source (output valid, output out_char, output has_char,
                    output end_of_text, output truncated, input ready);
    modport sink   (input valid, input out_char, input has_char,
                    input end_of_text, input truncated, output ready);
endinterface

### rtl/core/ulf_step.sv
// ----------------------------------------------------------------------------
// ulf_step
// Per-byte decode, fold, leet map, repeat collapse and limit checks.
// Pure next-state logic; the registers live in the top level.
// ----------------------------------------------------------------------------
module ulf_step import ulf_pkg::*; (
    input  t_state     i_st,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  t_limit     i_pre_limit,
    input  t_limit     i_out_limit,
    output t_state     o_st,
    output t_result    o_res,
    output logic       o_has_res
);

    always_comb begin
        t_state     st;
        logic       have;
        logic       emit;
        logic [7:0] ch;

        st   = i_st;
        have = 1'b0;
        emit = 1'b0;
        ch   = '0;

        // Byte decode
        if (!st.stopped) begin
            if (st.c3_pend) begin
                st.c3_pend = 1'b0;
                have       = 1'b1;
                if (i_byte == '0) begin
                    ch         = CH_QUEST;
                    st.stopped = 1'b1;
                end else begin
                    ch = fold_second(i_byte);
                end
            end else if (st.skip_left != 2'd0) begin
                if (i_byte == '0) begin
                    st.skip_left = 2'd0;
                    st.stopped   = 1'b1;
                end else begin
                    st.skip_left = st.skip_left - 2'd1;
                end
            end else if (i_byte == '0) begin
                st.stopped = 1'b1;
            end else if (t_cmp'(st.produced) >= t_cmp'(i_pre_limit)) begin
                st.cut     = 1'b1;
                st.stopped = 1'b1;
            end else if (!i_byte[7]) begin
                have = 1'b1;
                ch   = to_lower(i_byte);
            end else if (i_byte == LEAD_C3) begin
                st.c3_pend = 1'b1;
            end else begin
                have         = 1'b1;
                ch           = CH_QUEST;
                st.skip_left = seq_skip(i_byte);
            end
            // lead byte with no partner at end of text
            if (i_last && st.c3_pend) begin
                st.c3_pend = 1'b0;
                have       = 1'b1;
                ch         = CH_QUEST;
            end
        end

        // Counting, output limit, leet and collapse
        if (have) begin
            if (st.produced != COUNT_MAX) st.produced = st.produced + 1'b1;
            if (t_cmp'(st.emitted) >= t_cmp'(i_out_limit)) begin
                st.cut     = 1'b1;
                st.stopped = 1'b1;
            end else begin
                ch = leet(ch);
                if (!(st.emitted >= COUNT_TWO && ch == st.last_out
                      && ch == st.second_out)) begin
                    st.second_out = st.last_out;
                    st.last_out   = ch;
                    if (st.emitted != COUNT_MAX) st.emitted = st.emitted + 1'b1;
                    emit = 1'b1;
                end
            end
        end

        o_res.out_char    = emit ? ch : 8'h00;
        o_res.has_char    = emit;
        o_res.end_of_text = i_last;
        o_res.truncated   = st.cut;
        o_has_res         = emit | i_last;

        // fresh state for the next text
        if (i_last) st = '0;
        o_st = st;
    end

endmodule

### rtl/core/utf8_fold_leet_normalizer.sv
// ----------------------------------------------------------------------------
// utf8_fold_leet_normalizer
// Path: an accepted input beat passes the input register, then the per-byte
//   logic into the result register, before its result beat.
// Throughput: one byte per cycle while the result slot is free or draining; the text state updates once per byte.
// Reset: synchronous active low; clears text state and both valid flags,
//   limits return to pre 4090 and out 4095.
// ----------------------------------------------------------------------------
module utf8_fold_leet_normalizer import ulf_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  t_cfg_idx     i_cfg_idx,
    input  t_limit       i_cfg_data,
    ulf_in_if.sink       i_in,
    ulf_out_if.source    o_out
);

    t_limit     r_pre_limit, r_out_limit;
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    t_state     r_st, n_st;
    logic       r_out_vld;
    t_result    r_out, n_out;
    logic       n_has_res;
    logic       fire;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_limit <= PRE_LIMIT_RST;
            r_out_limit <= OUT_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PRE_LIMIT: r_pre_limit <= i_cfg_data;
                REG_OUT_LIMIT: r_out_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage advances when the result slot is free or draining
    assign fire       = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || fire;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
            r_in_last <= i_in.is_last;
        end
    end

    ulf_step u_step (
        .i_st        (r_st),
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .i_pre_limit (r_pre_limit),
        .i_out_limit (r_out_limit),
        .o_st        (n_st),
        .o_res       (n_out),
        .o_has_res   (n_has_res)
    );

    // Text state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (fire) begin
            r_st <= n_st;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= n_has_res;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && n_has_res) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.out_char    = r_out.out_char;
    assign o_out.has_char    = r_out.has_char;
    assign o_out.end_of_text = r_out.end_of_text;
    assign o_out.truncated   = r_out.truncated;

    // A beat without a character only closes a text
    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out.has_char |-> r_out.end_of_text)
        else $error("result beat with no character and no end of text");

    a_empty_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out.has_char |-> r_out.out_char == 8'h00)
        else $error("character code set on a beat without a character");

    // The last byte of a text leaves clean state behind
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in_last |=> r_st == '0)
        else $error("text state not cleared after last byte");

    a_emit_le_produce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> r_st.emitted <= r_st.produced)
        else $error("more characters emitted than produced");

endmodule
